// File: hdl/mmc_pkg.sv
package mmc_pkg;

  // table geometry
  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);

  // field widths
  localparam int NODE_W  = 7;
  localparam int COUNT_W = 6;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 3;

  // free registers after reset, meaning none
  localparam logic [NODE_W-1:0] FREE_RESET = NODE_W'(64);
  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(64);

  // front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // config register map
  localparam int PADDR_W = 3;
  localparam logic REG_NODE_COUNT = 1'b0;

  // input modes
  localparam logic [MODE_W-1:0] MODE_LOAD_MATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_FREE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE      = 2'd2;

  // work class decided by the front
  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD_MATE,
    OP_LOAD_FREE,
    OP_MOVE
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STAY   = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_ADD    = 3'd2,
    KIND_SWAP_U = 3'd3,
    KIND_SWAP_V = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_WR2,
    B_WR3
  } back_state_t;

  typedef struct packed {
    op_t                op;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [COUNT_W-1:0] pair_cnt;
  } work_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    kind_t              kind;
    logic [COUNT_W-1:0] pair_count;
    logic [NODE_W-1:0]  free_low;
    logic [NODE_W-1:0]  free_high;
    logic [NODE_W-1:0]  mate_a;
    logic [NODE_W-1:0]  mate_b;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [NODE_W-1:0] data;
  } mem_wr_t;

endpackage

// File: hdl/mmc_front.sv
module mmc_front
  import mmc_pkg::*;
(
  input  logic               start,
  input  logic [MODE_W-1:0]  mode,
  input  logic [NODE_W-1:0]  node_a,
  input  logic [NODE_W-1:0]  node_b,
  input  logic [COUNT_W-1:0] pair_count_in,
  input  logic [NODE_W-1:0]  node_count,
  input  q_stat_t            q_stat,
  output logic               busy,
  output logic               push,
  output work_t              word
);

  logic [NODE_W-1:0] half;
  logic a_in_table, b_in_table, edge_ok;

  assign half       = node_count >> 1;
  assign a_in_table = 32'(node_a) < MAX_NODES;
  assign b_in_table = 32'(node_b) < MAX_NODES;

  // u in group zero, v in group one, both inside the table
  assign edge_ok = (node_a < half) && (node_b >= half) && (node_b < node_count) &&
                   a_in_table && b_in_table;

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  // classify the word
  always_comb begin
    word.node_a   = node_a;
    word.node_b   = node_b;
    word.pair_cnt = pair_count_in;
    word.op       = OP_NOP;
    unique case (mode)
      MODE_LOAD_MATE: word.op = a_in_table ? OP_LOAD_MATE : OP_NOP;
      MODE_LOAD_FREE: word.op = OP_LOAD_FREE;
      MODE_MOVE:      word.op = edge_ok ? OP_MOVE : OP_NOP;
      default:        word.op = OP_NOP;
    endcase
  end

endmodule

// File: hdl/mmc_queue.sv
module mmc_queue
  import mmc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  work_t   word_in,
  input  logic    pop,
  output work_t   word_out,
  output q_stat_t q_stat
);

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (32'(p) == QUEUE_DEPTH - 1) return '0;
    return p + QPTR_W'(1);
  endfunction

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign word_out     = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= word_in;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full || pop) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count past depth");
`endif

endmodule

// File: hdl/mmc_back.sv
module mmc_back
  import mmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [NODE_W-1:0] node_count,
  input  q_stat_t           q_stat,
  input  work_t             head,
  output logic              pop,
  output logic              done,
  output result_t           res
);

  back_state_t state, state_next;

  // mate table: one write port, two registered read ports
  logic [NODE_W-1:0] mate_mem [MAX_NODES];
  logic [NODE_W-1:0] rd_a, rd_b;
  logic [IDX_W-1:0]  raddr_a, raddr_b;
  mem_wr_t           wport;

  // item under work and pending writes
  work_t   cur;
  mem_wr_t pend2, pend3;
  mem_wr_t w1, w2, w3;

  logic [COUNT_W-1:0] pairs_matched, pairs_next;
  logic [NODE_W-1:0]  free_low, free_low_next;
  logic [NODE_W-1:0]  free_high, free_high_next;
  result_t            res_next;

  logic [NODE_W-1:0] n, u, v, mu, mv;
  logic              a_in, b_in, fu, fv, perfect, near;

  assign pop     = (state == B_IDLE) && !q_stat.empty;
  assign raddr_a = IDX_W'(head.node_a);
  assign raddr_b = IDX_W'(head.node_b);

  // memory
  always_ff @(posedge clk) begin
    rd_a <= mate_mem[raddr_a];
    rd_b <= mate_mem[raddr_b];
    if (wport.en) mate_mem[IDX_W'(wport.addr)] <= wport.data;
  end

  // write port select
  always_comb begin
    unique case (state)
      B_EXEC:  wport = w1;
      B_WR2:   wport = pend2;
      B_WR3:   wport = pend3;
      default: wport = '0;
    endcase
  end

  assign n    = node_count;
  assign u    = cur.node_a;
  assign v    = cur.node_b;
  assign mu   = rd_a;
  assign mv   = rd_b;
  assign a_in = 32'(cur.node_a) < MAX_NODES;
  assign b_in = 32'(cur.node_b) < MAX_NODES;
  assign fu   = mu >= n;
  assign fv   = mv >= n;
  assign perfect = {pairs_matched, 1'b0} == n;
  assign near    = ({1'b0, pairs_matched, 1'b0} + 8'd2) == {1'b0, n};

  // move decision and write list
  always_comb begin
    pairs_next     = pairs_matched;
    free_low_next  = free_low;
    free_high_next = free_high;
    w1 = '0;
    w2 = '0;
    w3 = '0;
    res_next.kind   = KIND_STAY;
    res_next.mate_a = a_in ? rd_a : n;
    res_next.mate_b = b_in ? rd_b : n;
    unique case (cur.op)
      OP_LOAD_MATE: begin
        w1 = '{en: 1'b1, addr: u, data: v};
        res_next.mate_a = v;
        res_next.mate_b = b_in ? ((v == u) ? v : rd_b) : n;
      end
      OP_LOAD_FREE: begin
        pairs_next     = cur.pair_cnt;
        free_low_next  = u;
        free_high_next = v;
      end
      OP_MOVE: begin
        priority if (perfect && mu == v) begin
          res_next.kind   = KIND_REMOVE;
          w1 = '{en: 1'b1, addr: u, data: n};
          w2 = '{en: 1'b1, addr: v, data: n};
          pairs_next      = pairs_matched - COUNT_W'(1);
          free_low_next   = u;
          free_high_next  = v;
          res_next.mate_a = n;
          res_next.mate_b = n;
        end else if (near && fu && fv) begin
          res_next.kind   = KIND_ADD;
          w1 = '{en: 1'b1, addr: u, data: v};
          w2 = '{en: 1'b1, addr: v, data: u};
          pairs_next      = pairs_matched + COUNT_W'(1);
          free_low_next   = n;
          free_high_next  = n;
          res_next.mate_a = v;
          res_next.mate_b = u;
        end else if (near && !fu && fv) begin
          // partner of u becomes the free node of group one
          res_next.kind   = KIND_SWAP_U;
          w1 = '{en: (32'(mu) < MAX_NODES), addr: mu, data: n};
          w2 = '{en: 1'b1, addr: u, data: v};
          w3 = '{en: 1'b1, addr: v, data: u};
          free_high_next  = mu;
          res_next.mate_a = v;
          res_next.mate_b = u;
        end else if (near && fu && !fv) begin
          // partner of v becomes the free node of group zero
          res_next.kind   = KIND_SWAP_V;
          w1 = '{en: (32'(mv) < MAX_NODES), addr: mv, data: n};
          w2 = '{en: 1'b1, addr: u, data: v};
          w3 = '{en: 1'b1, addr: v, data: u};
          free_low_next   = mv;
          res_next.mate_a = v;
          res_next.mate_b = u;
        end else begin
          res_next.kind = KIND_STAY;
        end
      end
      default: ;
    endcase
    res_next.pair_count = pairs_next;
    res_next.free_low   = free_low_next;
    res_next.free_high  = free_high_next;
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_stat.empty) state_next = B_EXEC;
      B_EXEC: state_next = w2.en ? B_WR2 : B_IDLE;
      B_WR2:  state_next = pend3.en ? B_WR3 : B_IDLE;
      B_WR3:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= 1'b0;
      pairs_matched <= '0;
      free_low      <= FREE_RESET;
      free_high     <= FREE_RESET;
    end else begin
      done <= (state == B_EXEC);
      if (state == B_EXEC) begin
        pairs_matched <= pairs_next;
        free_low      <= free_low_next;
        free_high     <= free_high_next;
      end
    end
  end

  // payload registers; the write slots are only read after an execute cycle
  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (state == B_EXEC) begin
      res   <= res_next;
      pend2 <= w2;
      pend3 <= w3;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == B_EXEC) else $error("result without execute");
  a_wr3_after_wr2: assert property (@(posedge clk) disable iff (rst)
    state == B_WR3 |-> $past(state) == B_WR2) else $error("third write out of order");
  a_pop_idle_only: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == B_EXEC) else $error("pop not followed by execute");
`endif

endmodule

// File: hdl/matching_markov_chain_step.sv
// Channel  | Handshake               | Words
// ---------+-------------------------+------------------------------------------------
// input    | start / busy            | mode, node_a, node_b, pair_count_in
// result   | done (one-cycle strobe) | move_kind, pair_count, free_low, free_high,
//          |                         | mate_of_a, mate_of_b
// config   | APB psel/penable/pready | node_count at byte address 0
//
// Back end states per word: idle and execute for loads and stays, then WR2 for remove and
// add, WR2 and WR3 for a swap: the mate table has one write port, so each write takes a state.
// The result strobe comes in the cycle after the execute cycle.
// A two-word queue sits between front and back; busy is high only while it is full.
// Synchronous reset clears the queue, the sequencer, the count and the free nodes;
// the mate table is not cleared and must be loaded before use.
// The receiver cannot stall: done marks every result for exactly one cycle.
module matching_markov_chain_step
  import mmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode,
  input  logic [NODE_W-1:0]  node_a,
  input  logic [NODE_W-1:0]  node_b,
  input  logic [COUNT_W-1:0] pair_count_in,
  // results
  output logic               done,
  output logic [KIND_W-1:0]  move_kind,
  output logic [COUNT_W-1:0] pair_count,
  output logic [NODE_W-1:0]  free_low,
  output logic [NODE_W-1:0]  free_high,
  output logic [NODE_W-1:0]  mate_of_a,
  output logic [NODE_W-1:0]  mate_of_b,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [NODE_W-1:0] node_count;
  logic              push, pop;
  work_t             front_word, head_word;
  q_stat_t           q_stat;
  result_t           res;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
      node_count <= pwdata[NODE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count) : '0;

  mmc_front u_front (
    .start         (start),
    .mode          (mode),
    .node_a        (node_a),
    .node_b        (node_b),
    .pair_count_in (pair_count_in),
    .node_count    (node_count),
    .q_stat        (q_stat),
    .busy          (busy),
    .push          (push),
    .word          (front_word)
  );

  mmc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .word_in  (front_word),
    .pop      (pop),
    .word_out (head_word),
    .q_stat   (q_stat)
  );

  mmc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .node_count (node_count),
    .q_stat     (q_stat),
    .head       (head_word),
    .pop        (pop),
    .done       (done),
    .res        (res)
  );

  // result fields
  assign move_kind  = res.kind;
  assign pair_count = res.pair_count;
  assign free_low   = res.free_low;
  assign free_high  = res.free_high;
  assign mate_of_a  = res.mate_a;
  assign mate_of_b  = res.mate_b;

endmodule
